/* hdl/nnis_pkg.sv */
// Package for the nearest-neighbor image scaler: field widths, register
// indexes, payload structs and the dimension clamp helper.
// No dependencies.
package nnis_pkg;

    localparam int COLOR_W   = 8;
    localparam int PIX_W     = 3 * COLOR_W;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_DEPTH = 2;

    localparam int MAX_PIXELS_DEF = 65536;
    localparam int MAX_SIDE_DEF   = 1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    // Request types
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COLOR_W-1:0] in_red;
        logic [COLOR_W-1:0] in_green;
        logic [COLOR_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic               frame_last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] source_width;
        logic [CFG_W-1:0] source_height;
        logic [CFG_W-1:0] target_width;
        logic [CFG_W-1:0] target_height;
    } t_cfg;

    // Zero acts as one, anything above max_side saturates.
    function automatic logic [CFG_W-1:0] dim_eff(input logic [CFG_W-1:0] v,
                                                 input int max_side);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > max_side) begin
            r = CFG_W'(max_side);
        end
        return r;
    endfunction

endpackage

/* hdl/nnis_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/nnis_fifo.sv */
// Small command queue between the front and back parts of the scaler.
// No dependencies.
module nnis_fifo #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hdl/nnis_front.sv */
// Front part of the scaler: accepts transactions, writes source pixels to
// the frame store, walks the output raster and queues read commands.
// Depends on nnis_pkg.
module nnis_front #(
    parameter int MAX_PIXELS = nnis_pkg::MAX_PIXELS_DEF,
    parameter int MAX_SIDE   = nnis_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  nnis_pkg::t_in_item            i_item,
    output logic                          o_full,
    input  nnis_pkg::t_cfg                i_cfg,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [2*$clog2(MAX_SIDE):0]   o_q_data,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_PIXELS)-1:0] o_wr_addr,
    output logic [nnis_pkg::PIX_W-1:0]    o_wr_data
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int LW = $clog2(MAX_PIXELS + 1);

    logic [LW-1:0] r_load_pos, n_load_pos;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [SW-1:0] tw, th;
    logic [SW-1:0] col_c, row_c, col_n, row_n;
    logic          last;
    logic          accept;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        tw = SW'(nnis_pkg::dim_eff(i_cfg.target_width, MAX_SIDE));
        th = SW'(nnis_pkg::dim_eff(i_cfg.target_height, MAX_SIDE));

        // pull stale counters back inside a shrunken target
        col_c = SW'(r_col);
        row_c = SW'(r_row);
        if (col_c >= tw) begin
            col_c = '0;
            row_c = row_c + SW'(1);
        end
        if (row_c >= th) begin
            row_c = '0;
        end
        last = (col_c == tw - SW'(1)) && (row_c == th - SW'(1));

        col_n = col_c + SW'(1);
        row_n = row_c;
        if (col_n >= tw) begin
            col_n = '0;
            row_n = row_c + SW'(1);
            if (row_n >= th) begin
                row_n = '0;
            end
        end

        n_load_pos = r_load_pos;
        n_col      = r_col;
        n_row      = r_row;
        o_wr_en    = 1'b0;
        o_q_push   = 1'b0;
        if (accept) begin
            if (i_item.req_type == nnis_pkg::REQ_STORE) begin
                if (r_load_pos < LW'(MAX_PIXELS)) begin
                    o_wr_en    = 1'b1;
                    n_load_pos = r_load_pos + LW'(1);
                end
            end else begin
                o_q_push = 1'b1;
                n_col    = col_n[CW-1:0];
                n_row    = row_n[CW-1:0];
            end
        end
    end

    assign o_q_data  = {last, row_c[CW-1:0], col_c[CW-1:0]};
    assign o_wr_addr = r_load_pos[AW-1:0];
    assign o_wr_data = {i_item.in_red, i_item.in_green, i_item.in_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_load_pos <= n_load_pos;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

endmodule

/* hdl/nnis_back.sv */
// Back part of the scaler: maps a queued output position to a source
// position with two bit-serial dividers, reads the frame store and holds
// the result. Depends on nnis_pkg.
module nnis_back #(
    parameter int MAX_PIXELS = nnis_pkg::MAX_PIXELS_DEF,
    parameter int MAX_SIDE   = nnis_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nnis_pkg::t_cfg                i_cfg,
    input  logic                          i_q_empty,
    input  logic [2*$clog2(MAX_SIDE):0]   i_q_data,
    output logic                          o_q_pop,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_PIXELS)-1:0] o_rd_addr,
    input  logic [nnis_pkg::PIX_W-1:0]    i_rd_data,
    input  logic                          i_pop,
    output logic                          o_empty,
    output nnis_pkg::t_out_item           o_item
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int PW    = CW + SW;
    localparam int AW    = $clog2(MAX_PIXELS);
    localparam int IW    = (PW > AW) ? PW : AW + 1;
    localparam int CNT_W = $clog2(PW);
    localparam int CB    = nnis_pkg::COLOR_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ADDR,
        B_READ,
        B_DATA
    } t_state;

    t_state              r_state;
    logic [PW-1:0]       r_nx, r_ny;
    logic [SW-1:0]       r_rx, r_ry;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_last;
    logic [IW-1:0]       r_idx;
    logic                r_zero;
    logic                r_out_valid;
    nnis_pkg::t_out_item r_out_item;

    logic [SW-1:0] sw, sh, tw, th;
    logic [SW:0]   tx, ty;
    logic          gex, gey;
    logic [SW-1:0] nrx, nry;
    logic [CW-1:0] q_col, q_row;
    logic          q_last;
    logic [IW-1:0] idx_calc;
    logic          slot_free;

    always_comb begin
        sw = SW'(nnis_pkg::dim_eff(i_cfg.source_width, MAX_SIDE));
        sh = SW'(nnis_pkg::dim_eff(i_cfg.source_height, MAX_SIDE));
        tw = SW'(nnis_pkg::dim_eff(i_cfg.target_width, MAX_SIDE));
        th = SW'(nnis_pkg::dim_eff(i_cfg.target_height, MAX_SIDE));

        // one restoring step per axis, divisor is the target size
        tx  = {r_rx, r_nx[PW-1]};
        ty  = {r_ry, r_ny[PW-1]};
        gex = (tx >= {1'b0, tw});
        gey = (ty >= {1'b0, th});
        nrx = gex ? SW'(tx - {1'b0, tw}) : tx[SW-1:0];
        nry = gey ? SW'(ty - {1'b0, th}) : ty[SW-1:0];

        idx_calc = IW'(PW'(r_ny[CW-1:0]) * PW'(sw)) + IW'(r_nx[CW-1:0]);
    end

    assign q_col     = i_q_data[CW-1:0];
    assign q_row     = i_q_data[2*CW-1:CW];
    assign q_last    = i_q_data[2*CW];
    assign slot_free = !r_out_valid || i_pop;
    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign o_rd_en   = (r_state == B_READ) && slot_free;
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_nx    <= PW'(q_col) * PW'(sw);
                        r_ny    <= PW'(q_row) * PW'(sh);
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_cnt   <= '0;
                        r_last  <= q_last;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rx  <= nrx;
                    r_ry  <= nry;
                    r_nx  <= {r_nx[PW-2:0], gex};
                    r_ny  <= {r_ny[PW-2:0], gey};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(PW - 1)) begin
                        r_state <= B_ADDR;
                    end
                end
                B_ADDR: begin
                    r_idx   <= idx_calc;
                    r_state <= B_READ;
                end
                B_READ: begin
                    if (slot_free) begin
                        r_zero  <= (r_idx >= IW'(MAX_PIXELS));
                        r_state <= B_DATA;
                    end
                end
                B_DATA: begin
                    r_out_valid           <= 1'b1;
                    r_out_item.out_red    <= r_zero ? '0 : i_rd_data[3*CB-1:2*CB];
                    r_out_item.out_green  <= r_zero ? '0 : i_rd_data[2*CB-1:CB];
                    r_out_item.out_blue   <= r_zero ? '0 : i_rd_data[CB-1:0];
                    r_out_item.frame_last <= r_last;
                    r_state               <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/nearest_neighbor_image_scaler_top.sv */
// Nearest-neighbor image scaler, top level. A store transaction
// writes one RGB source pixel into the frame store at the next raster
// position; stores past MAX_PIXELS entries are dropped. A read
// transaction yields the next pixel of the resized image in raster order,
// taken from source column floor(x*source_width/target_width) and row
// floor(y*source_height/target_height), with frame_last on the final pixel
// of the frame. In the back part a read fetches the command and forms the
// products, runs the bit-serial dividers that produce one quotient bit per
// cycle, forms the store address, reads the store and registers the
// result. The back part waits before the store read while an earlier
// result is still unpopped. The front keeps accepting stores and queuing
// reads while the back part works; it stops accepting anything once two
// reads are queued. No clearing pass is needed after reset. Write the
// configuration only while the block is idle.
// Depends on nnis_pkg, nnis_front, nnis_fifo, nnis_back and nnis_ram.
module nearest_neighbor_image_scaler_top #(
    parameter int MAX_PIXELS = nnis_pkg::MAX_PIXELS_DEF,
    parameter int MAX_SIDE   = nnis_pkg::MAX_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              push,
    input  nnis_pkg::t_in_item                i_in_item,
    output logic                              full,
    // result transactions
    output logic                              empty,
    input  logic                              pop,
    output nnis_pkg::t_out_item               o_out_item,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nnis_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int QW = 2 * CW + 1;
    localparam int AW = $clog2(MAX_PIXELS);

    nnis_pkg::t_cfg r_cfg;

    logic                       q_full, q_empty, q_push, q_pop;
    logic [QW-1:0]              q_wdata, q_rdata;
    logic                       wr_en, rd_en;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [nnis_pkg::PIX_W-1:0] wr_data, rd_data;

    // Configuration registers; all reset to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= nnis_pkg::CFG_W'(1);
            r_cfg.source_height <= nnis_pkg::CFG_W'(1);
            r_cfg.target_width  <= nnis_pkg::CFG_W'(1);
            r_cfg.target_height <= nnis_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nnis_pkg::REG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_wdata;
                nnis_pkg::REG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_wdata;
                nnis_pkg::REG_TARGET_WIDTH:  r_cfg.target_width  <= i_cfg_wdata;
                nnis_pkg::REG_TARGET_HEIGHT: r_cfg.target_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: stores go straight to the frame store, reads become
    // (column, row, last) commands.
    nnis_front #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_in_item),
        .o_full    (full),
        .i_cfg     (r_cfg),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Command queue decouples the two sides.
    nnis_fifo #(
        .WIDTH (QW),
        .DEPTH (nnis_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back: divide, address, read, hold the result.
    nnis_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

    // Frame store; the user must read an entry only after it was written.
    nnis_ram #(
        .WIDTH (nnis_pkg::PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

endmodule

/* hdl/nnis_checker.sv */
// Port-level checks for the nearest-neighbor image scaler, bound to the
// top level. Depends on nnis_pkg and nearest_neighbor_image_scaler_top.
module nnis_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input nnis_pkg::t_out_item o_out_item
);

    // Reset leaves no result waiting and room for input.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("scaler not clean after reset");

    // Single result slot: a taken result leaves the output empty.
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("result slot refilled in the pop cycle");

    // The command queue only fills through an accepted transaction.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted push");

    // A waiting result holds until taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed or vanished");

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_checker (.*);

/* verif/nearest_neighbor_image_scaler_top_tb.sv */
// Self-checking testbench for the nearest-neighbor image scaler: a directed
// table, then random store/read traffic and reads that fall past the store.
// Depends on nnis_pkg and nearest_neighbor_image_scaler_top.
module nearest_neighbor_image_scaler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_MAX        = nnis_pkg::MAX_PIXELS_DEF;
    localparam int SIDE_MAX       = nnis_pkg::MAX_SIDE_DEF;
    localparam int SETTLE_CYCLES  = 48;    // covers a read in the back part plus queueing
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int DIR_ROWS       = 30;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // One line of the directed table: either a transaction or a register write.
    typedef struct packed {
        t_row_kind                            kind;
        nnis_pkg::t_in_item                   item;
        logic [nnis_pkg::CFG_IDX_W-1:0]       reg_idx;
        logic [nnis_pkg::CFG_W-1:0]           reg_val;
        logic                                 typed;   // want holds a hand-written result
        nnis_pkg::t_out_item                  want;
    } t_stim_row;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            push        = 1'b0;
    nnis_pkg::t_in_item              i_in_item   = '0;
    logic                            full;
    logic                            empty;
    logic                            pop         = 1'b0;
    nnis_pkg::t_out_item             o_out_item;
    logic                            i_cfg_we    = 1'b0;
    logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [nnis_pkg::CFG_W-1:0]      i_cfg_wdata = '0;

    nearest_neighbor_image_scaler_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (i_in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scaler prediction: own copy of frame store, raster counters, regs
    // ------------------------------------------------------------------
    logic [nnis_pkg::PIX_W-1:0] src_pixels [PIX_MAX];
    int unsigned                src_loaded = 0;
    int unsigned                out_x      = 0;
    int unsigned                out_y      = 0;
    logic [nnis_pkg::CFG_W-1:0] reg_sw     = nnis_pkg::CFG_W'(1);
    logic [nnis_pkg::CFG_W-1:0] reg_sh     = nnis_pkg::CFG_W'(1);
    logic [nnis_pkg::CFG_W-1:0] reg_tw     = nnis_pkg::CFG_W'(1);
    logic [nnis_pkg::CFG_W-1:0] reg_th     = nnis_pkg::CFG_W'(1);

    nnis_pkg::t_out_item pending_pixels [$];   // predicted pixels, oldest first
    int unsigned         err_count      = 0;
    int unsigned         rand_items     = 0;
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_idle_pct  = 0;
    int unsigned         stall_cycles   = 0;
    bit                  busy           = 1'b0; // transactions sent since last quiesce

    // A register holding 0 scales as 1; anything past the side limit saturates.
    function automatic int unsigned eff_side(input logic [nnis_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > SIDE_MAX) return SIDE_MAX;
        return int'(v);
    endfunction

    function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Returns 1 and the expected pixel for a read, 0 for a store.
    function automatic bit predict_scaled_pixel(input nnis_pkg::t_in_item it,
                                                output nnis_pkg::t_out_item px);
        int unsigned                sw, sh, tw, th, sx, sy, addr;
        logic [nnis_pkg::PIX_W-1:0] rgb;
        px = '0;
        if (it.req_type == nnis_pkg::REQ_STORE) begin
            // stores past the end of the store are dropped for good
            if (src_loaded < PIX_MAX) begin
                src_pixels[src_loaded] = {it.in_red, it.in_green, it.in_blue};
                src_loaded++;
            end
            return 1'b0;
        end
        sw = eff_side(reg_sw);
        sh = eff_side(reg_sh);
        tw = eff_side(reg_tw);
        th = eff_side(reg_th);
        // target shrunk mid-frame: pull the counters back inside first
        if (out_x >= tw) begin
            out_x = 0;
            out_y++;
        end
        if (out_y >= th) out_y = 0;
        sx   = (out_x * sw) / tw;
        sy   = (out_y * sh) / th;
        addr = sy * sw + sx;
        rgb  = (addr < PIX_MAX) ? src_pixels[addr] : '0;
        px.out_red    = rgb[23:16];
        px.out_green  = rgb[15:8];
        px.out_blue   = rgb[7:0];
        px.frame_last = (out_x == tw - 1) && (out_y == th - 1);
        out_x++;
        if (out_x >= tw) begin
            out_x = 0;
            out_y++;
            if (out_y >= th) out_y = 0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t: MISMATCH %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s: got %h, expected %h", name, got_v, want_v));
    endtask

    task automatic check_pixel(input nnis_pkg::t_out_item got);
        nnis_pkg::t_out_item want;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %h popped with none expected", got));
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("out_red",    got.out_red,    want.out_red);
        compare_field("out_green",  got.out_green,  want.out_green);
        compare_field("out_blue",   got.out_blue,   want.out_blue);
        compare_field("frame_last", 8'(got.frame_last), 8'(want.frame_last));
    endtask

    // Result side: pop transaction is sampled at the edge, then pop is re-rolled.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_pixel(o_out_item);
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any transaction or register write restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_we) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // One input transaction; returns right after the edge that accepted it.
    task automatic send_item(input nnis_pkg::t_in_item it, input bit use_typed = 1'b0,
                             input nnis_pkg::t_out_item typed_px = '0);
        nnis_pkg::t_out_item px;
        bit                  has_px;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        has_px = predict_scaled_pixel(it, px);
        if (has_px) pending_pixels.push_back(use_typed ? typed_px : px);
        busy = 1'b1;
    endtask

    // Stop sending, drain every expected pixel, then give the back end time
    // to retire anything that produces no result.
    task automatic quiesce();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        busy = 1'b0;
    endtask

    task automatic write_reg(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nnis_pkg::CFG_W-1:0] val);
        if (busy) quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            nnis_pkg::REG_SOURCE_WIDTH:  reg_sw = val;
            nnis_pkg::REG_SOURCE_HEIGHT: reg_sh = val;
            nnis_pkg::REG_TARGET_WIDTH:  reg_tw = val;
            nnis_pkg::REG_TARGET_HEIGHT: reg_th = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [nnis_pkg::CFG_W-1:0] sw,
                                 input logic [nnis_pkg::CFG_W-1:0] sh,
                                 input logic [nnis_pkg::CFG_W-1:0] tw,
                                 input logic [nnis_pkg::CFG_W-1:0] th);
        write_reg(nnis_pkg::REG_SOURCE_WIDTH,  sw);
        write_reg(nnis_pkg::REG_SOURCE_HEIGHT, sh);
        write_reg(nnis_pkg::REG_TARGET_WIDTH,  tw);
        write_reg(nnis_pkg::REG_TARGET_HEIGHT, th);
    endtask

    function automatic nnis_pkg::t_in_item random_item(input int unsigned store_pct);
        nnis_pkg::t_in_item it;
        it.req_type = ($urandom_range(99) < store_pct) ? nnis_pkg::REQ_STORE
                                                       : nnis_pkg::REQ_READ;
        {it.in_red, it.in_green, it.in_blue} = nnis_pkg::PIX_W'($urandom);
        return it;
    endfunction

    // Register code for an effective size: 1 sometimes written as 0, the side
    // limit sometimes written as an oversized value.
    function automatic logic [nnis_pkg::CFG_W-1:0] code_side(input int unsigned side);
        if (side == 1 && $urandom_range(3) == 0) return '0;
        if (side == SIDE_MAX && $urandom_range(1) == 0)
            return nnis_pkg::CFG_W'($urandom_range(SIDE_MAX + 1, (1 << nnis_pkg::CFG_W) - 1));
        return nnis_pkg::CFG_W'(side);
    endfunction

    // Random segments: a fresh setting whose source fits in what has been loaded or, once the
    // store is full, is full size (so no unwritten entry is ever read), then a store/read mix.
    task automatic run_random(input int unsigned upto);
        int unsigned sw, sh, tw, th, max_sh, n_items;
        while (rand_items < upto) begin
            if (src_loaded >= PIX_MAX && $urandom_range(3) == 0) begin
                sw = SIDE_MAX;
                sh = SIDE_MAX;
            end else begin
                sw = ($urandom_range(5) == 0) ? lesser(SIDE_MAX, src_loaded)
                                              : $urandom_range(1, lesser(16, src_loaded));
                max_sh = (src_loaded >= PIX_MAX) ? SIDE_MAX
                                                 : lesser(SIDE_MAX, src_loaded / sw);
                sh = ($urandom_range(5) == 0) ? max_sh
                                              : $urandom_range(1, lesser(16, max_sh));
            end
            // mostly small targets so frames complete and frame_last shows up
            tw = ($urandom_range(7) == 0) ? SIDE_MAX : $urandom_range(1, 12);
            th = ($urandom_range(7) == 0) ? SIDE_MAX : $urandom_range(1, 12);
            apply_setting(code_side(sw), code_side(sh), code_side(tw), code_side(th));
            n_items = $urandom_range(15, 45);
            repeat (n_items) begin
                send_item(random_item(30));
                rand_items++;
            end
        end
    endtask

    function automatic t_stim_row row_store(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = '{req_type: nnis_pkg::REQ_STORE, in_red: r, in_green: g, in_blue: b};
        return row;
    endfunction

    function automatic t_stim_row row_read();
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = '{req_type: nnis_pkg::REQ_READ, in_red: 8'hc3, in_green: 8'h3c,
                     in_blue: 8'h96};
        return row;
    endfunction

    function automatic t_stim_row row_read_exp(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic last);
        t_stim_row row;
        row = row_read();
        row.typed = 1'b1;
        row.want  = '{out_red: r, out_green: g, out_blue: b, frame_last: last};
        return row;
    endfunction

    function automatic t_stim_row row_reg(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [nnis_pkg::CFG_W-1:0] val);
        t_stim_row row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    t_stim_row dir_rows [DIR_ROWS];

    initial begin
        dir_rows = '{
            // extremes into the first four entries
            row_store(8'hff, 8'hff, 8'hff),
            row_store(8'h00, 8'h00, 8'h00),
            row_store(8'h80, 8'h01, 8'h7f),
            row_store(8'h01, 8'hfe, 8'h80),
            // reset sizes are 1x1: every read is entry 0 and ends the frame
            row_read_exp(8'hff, 8'hff, 8'hff, 1'b1),
            row_read_exp(8'hff, 8'hff, 8'hff, 1'b1),
            // 4x1 source stretched to 8 wide; heights written as 0 act as 1
            row_reg(nnis_pkg::REG_SOURCE_WIDTH, 11'd4),
            row_reg(nnis_pkg::REG_SOURCE_HEIGHT, 11'd0),
            row_reg(nnis_pkg::REG_TARGET_WIDTH, 11'd8),
            row_reg(nnis_pkg::REG_TARGET_HEIGHT, 11'd0),
            row_read(), row_read(), row_read(), row_read(), row_read(),
            // shrink the target width with the column counter past it
            row_reg(nnis_pkg::REG_TARGET_WIDTH, 11'd2),
            row_read(), row_read(),
            // one column, three rows; then shrink height with the row past it
            row_reg(nnis_pkg::REG_SOURCE_WIDTH, 11'd1),
            row_reg(nnis_pkg::REG_TARGET_WIDTH, 11'd1),
            row_reg(nnis_pkg::REG_TARGET_HEIGHT, 11'd3),
            row_read(), row_read(),
            row_reg(nnis_pkg::REG_TARGET_HEIGHT, 11'd1),
            row_read(),
            // oversized register values saturate at the side limit
            row_reg(nnis_pkg::REG_TARGET_WIDTH, 11'd2047),
            row_reg(nnis_pkg::REG_SOURCE_HEIGHT, 11'd1500),
            row_read(), row_read(),
            row_store(8'h5a, 8'ha5, 8'h3c)
        };

        // synchronous reset, held once at the start
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: sender idles 31%, receiver 66%
        send_idle_pct = 31;
        recv_idle_pct = 66;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        run_random(260);

        // phase 2: roles swapped
        send_idle_pct = 66;
        recv_idle_pct = 31;
        run_random(520);

        // phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // full-size source, one target column: row 0 reads entry 0, every
        // lower row lands past the store and reads as zero
        apply_setting(11'd2047, 11'd1024, 11'd1, 11'd5);
        repeat (20) send_item(random_item(0));
        apply_setting(11'd1024, 11'd2000, 11'd1, 11'd3);
        repeat (9) send_item(random_item(0));
        run_random(770);

        quiesce();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* nearest_neighbor_image_scaler_top.f */
hdl/nnis_pkg.sv
hdl/nnis_ram.sv
hdl/nnis_fifo.sv
hdl/nnis_front.sv
hdl/nnis_back.sv
hdl/nearest_neighbor_image_scaler_top.sv
hdl/nnis_checker.sv
verif/nearest_neighbor_image_scaler_top_tb.sv
